[rtl/assert_macros.svh]
// Assertion helper macros for the stroke font vector generator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property check under clock and synchronous reset
`define SFV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sfv check failed");
// Condition that must never be seen
`define SFV_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sfv forbidden condition");
`else
`define SFV_ASSERT(lbl, clk, rst, prop)
`define SFV_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/sfv_pkg.sv]
// Shared types, constants and fixed-point helpers of the stroke font vector generator.
// No dependencies; imported by sfv_mac and stroke_font_vector_generator.
`default_nettype none
package sfv_pkg;

   // Storage sizes
   localparam int VECTOR_WORDS = 4096;
   localparam int VADDR_W      = $clog2(VECTOR_WORDS);
   localparam int POINT_LIMIT  = 1024;
   localparam int PIDX_W       = $clog2(POINT_LIMIT) + 1;
   localparam int CODES        = 256;
   localparam int CODE_W       = 8;
   localparam int CNT_W        = 6;
   localparam int OFF_W        = 12;
   localparam int RES_DEPTH    = 64;
   localparam int RES_AW       = $clog2(RES_DEPTH);
   localparam int RES_W        = 65;    // {pen_down, y, x}

   // Arithmetic
   localparam int MUL_B_W = 18;
   localparam int ACC_W   = 50;
   localparam logic [MUL_B_W-1:0] Y_BIAS = 18'd5000;

   // Port widths
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DW    = 40;
   localparam int REQ_UW    = 3;
   localparam int RSP_DW    = 64;
   localparam int RSP_UW    = 2;

   typedef enum logic [1:0] {
      CMD_COUNT  = 2'd0,
      CMD_OFFSET = 2'd1,
      CMD_VECTOR = 2'd2,
      CMD_DRAW   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE_X = 3'd0,
      CSR_SHEAR   = 3'd1,
      CSR_SCALE_Y = 3'd2,
      CSR_ADVANCE = 3'd3,
      CSR_SMALL   = 3'd4
   } csr_type;

   // Control word for the shared multiply-accumulate unit
   typedef struct packed {
      logic issue;   // register a new product
      logic load;    // accumulator takes the product
      logic accum;   // accumulator adds the product
   } mac_ctl_type;

   // Saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
      else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
      else                                    r = v[31:0];
      return r;
   endfunction

   // Q.24 to Q.16, round half toward +infinity
   function automatic logic signed [63:0] rnd8(input logic signed [ACC_W-1:0] a);
      logic signed [63:0] w;
      w = {{(64-ACC_W){a[ACC_W-1]}}, a} + 64'sd128;
      return w >>> 8;
   endfunction

endpackage
`default_nettype wire

[rtl/sfv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the font tables, the font store and the result buffer.
`default_nettype none
module sfv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/sfv_mac.sv]
// Shared multiply-accumulate unit: one 32x18 signed multiplier, product register, accumulator.
// Depends on sfv_pkg.
`default_nettype none
module sfv_mac (
   input  wire logic                             clock,
   input  wire sfv_pkg::mac_ctl_type             ctl,
   input  wire logic signed [31:0]               op_a,
   input  wire logic signed [sfv_pkg::MUL_B_W-1:0] op_b,
   output logic signed [sfv_pkg::ACC_W-1:0]      acc
);
   import sfv_pkg::*;

   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // product stage
   always_comb begin
      prod_in = prod_ff;
      if (ctl.issue) begin
         prod_in = ACC_W'(op_a * op_b);
      end
   end

   // accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = prod_ff;
      end else if (ctl.accum) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

[rtl/stroke_font_vector_generator.sv]
// Stroke font vector generator: font tables, pair walker sequencer, result buffer.
// Depends on sfv_pkg, sfv_ram, sfv_mac and assert_macros.svh.
//
// A write word (pair count, start offset or font word) is taken on acceptance. A draw word
// looks up the tables in S_LOOK and S_LOAD, walks S_RDX to S_CHK per coordinate pair
// (S_VIS only if visible), closes the character in S_END and sends each result word
// through S_DRD and S_DLD, S_DRD waiting while rsp_tready holds the output register. A
// small-text draw steps T_OFF, T_ADV and T_LAST in S_END before its results go out. Each
// pair costs two reads of the font store and three passes through the shared multiplier.
// Results of one character are collected in a 64-entry buffer and sent once the character
// is finished, because the truncated flag and tlast are known only at its end. The final
// result word waits in the output register while the next request word is accepted.
`default_nettype none
`include "assert_macros.svh"
module stroke_font_vector_generator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_wr_en,
   input  wire logic [sfv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [31:0]                     csr_wdata,
   // request words
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [sfv_pkg::REQ_DW-1:0]      req_tdata,  // index, data, char_code, pad
   input  wire logic [sfv_pkg::REQ_UW-1:0]      req_tuser,  // cmd, first_char
   input  wire logic                            req_tlast,  // last_char
   // result words
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [sfv_pkg::RSP_DW-1:0]      rsp_tdata,  // x_coord, y_coord
   output logic      [sfv_pkg::RSP_UW-1:0]      rsp_tuser,  // pen_down, truncated
   output logic                                 rsp_tlast   // last
);
   import sfv_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE = 16'h0001,
      S_LOOK = 16'h0002,
      S_LOAD = 16'h0004,
      S_RDX  = 16'h0008,
      S_RDY  = 16'h0010,
      S_M0   = 16'h0020,
      S_M1   = 16'h0040,
      S_M2   = 16'h0080,
      S_M3   = 16'h0100,
      S_M4   = 16'h0200,
      S_EMIT = 16'h0400,
      S_VIS  = 16'h0800,
      S_CHK  = 16'h1000,
      S_END  = 16'h2000,
      S_DRD  = 16'h4000,
      S_DLD  = 16'h8000
   } state_type;

   // small-text uses a separate short path
   typedef enum logic [2:0] {
      T_OFF  = 3'b001,
      T_ADV  = 3'b010,
      T_LAST = 3'b100
   } st_type;

   // request fields
   logic [11:0]       f_index;
   logic [15:0]       f_data;
   logic [CODE_W-1:0] f_code;
   cmd_type           f_cmd;
   logic              f_first;
   assign f_index = req_tdata[11:0];
   assign f_data  = req_tdata[27:12];
   assign f_code  = req_tdata[35:28];
   assign f_cmd   = cmd_type'(req_tuser[1:0]);
   assign f_first = req_tuser[2];

   // configuration registers
   logic signed [31:0] scale_x_ff, shear_ff, scale_y_ff, advance_ff;
   logic               small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= '0;
         shear_ff   <= '0;
         scale_y_ff <= '0;
         advance_ff <= '0;
         small_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCALE_X: scale_x_ff <= csr_wdata;
            CSR_SHEAR:   shear_ff   <= csr_wdata;
            CSR_SCALE_Y: scale_y_ff <= csr_wdata;
            CSR_ADVANCE: advance_ff <= csr_wdata;
            CSR_SMALL:   small_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer state
   state_type             state_ff, state_in;
   st_type                st_ff, st_in;
   logic                  small_run_ff, small_run_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic                  first_ff, first_in;
   logic                  lastc_ff, lastc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      pair_ff, pair_in;
   logic [VADDR_W-1:0]    vaddr_ff, vaddr_in;
   logic [15:0]           wx_ff, wx_in;
   logic signed [MUL_B_W-1:0] iy_ff, iy_in;
   logic signed [31:0]    px_ff, px_in, py_ff, py_in;
   logic signed [31:0]    pen_x_ff, pen_x_in;
   logic [PIDX_W-1:0]     pidx_ff, pidx_in;
   logic                  pv_ff, pv_in;
   logic signed [31:0]    pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic                  halted_ff, halted_in;
   logic                  broke_ff, broke_in;
   logic                  trunc_ff, trunc_in;
   logic [RES_AW:0]       n_ff, n_in;
   logic [RES_AW:0]       rd_ptr_ff, rd_ptr_in;

   // output register
   logic                  rv_ff, rv_in;
   logic [RSP_DW-1:0]     rdata_ff, rdata_in;
   logic [RSP_UW-1:0]     ruser_ff, ruser_in;
   logic                  rlast_ff, rlast_in;

   // memories
   logic                  cnt_we, off_we, vec_we, buf_we;
   logic [CNT_W-1:0]      cnt_rd;
   logic [OFF_W-1:0]      off_rd;
   logic [15:0]           vec_rd;
   logic [VADDR_W-1:0]    vec_raddr;
   logic [RES_W-1:0]      buf_wdata, buf_rd;
   logic [RES_AW-1:0]     buf_raddr;

   // multiply-accumulate
   mac_ctl_type               mac_ctl;
   logic signed [31:0]        mac_a;
   logic signed [MUL_B_W-1:0] mac_b;
   logic signed [ACC_W-1:0]   acc;

   logic accept, out_free, at_end_lim;
   logic [PIDX_W:0] lim_sum;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rv_ff || rsp_tready;

   // table writes take place on acceptance
   assign cnt_we = accept && (f_cmd == CMD_COUNT)  && (f_index[11:8] == 4'd0);
   assign off_we = accept && (f_cmd == CMD_OFFSET) && (f_index[11:8] == 4'd0);
   assign vec_we = accept && (f_cmd == CMD_VECTOR) && (32'(f_index) < VECTOR_WORDS);

   sfv_ram #(.WIDTH(CNT_W), .DEPTH(CODES)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(f_index[CODE_W-1:0]),
      .wr_data(f_data[CNT_W-1:0]), .rd_addr(code_ff), .rd_data(cnt_rd));

   sfv_ram #(.WIDTH(OFF_W), .DEPTH(CODES)) u_off_ram (
      .clock(clock), .wr_en(off_we), .wr_addr(f_index[CODE_W-1:0]),
      .wr_data(f_data[OFF_W-1:0]), .rd_addr(code_ff), .rd_data(off_rd));

   assign vec_raddr = vec_we ? VADDR_W'(f_index) : vaddr_ff;

   sfv_ram #(.WIDTH(16), .DEPTH(VECTOR_WORDS)) u_vec_ram (
      .clock(clock), .wr_en(vec_we), .wr_addr(VADDR_W'(f_index)),
      .wr_data(f_data), .rd_addr(vec_raddr), .rd_data(vec_rd));

   assign buf_raddr = rd_ptr_ff[RES_AW-1:0];

   sfv_ram #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_ram (
      .clock(clock), .wr_en(buf_we), .wr_addr(n_ff[RES_AW-1:0]),
      .wr_data(buf_wdata), .rd_addr(buf_raddr), .rd_data(buf_rd));

   sfv_mac u_mac (
      .clock(clock), .ctl(mac_ctl), .op_a(mac_a), .op_b(mac_b), .acc(acc));

   // point limit checks
   assign lim_sum    = (PIDX_W+1)'(pidx_ff) + (PIDX_W+1)'(pv_ff);
   assign at_end_lim = (32'(pidx_ff) >= POINT_LIMIT - 2);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      st_in        = st_ff;
      small_run_in = small_run_ff;
      code_in      = code_ff;
      first_in     = first_ff;
      lastc_in     = lastc_ff;
      cnt_in       = cnt_ff;
      pair_in      = pair_ff;
      vaddr_in     = vaddr_ff;
      wx_in        = wx_ff;
      iy_in        = iy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pen_x_in     = pen_x_ff;
      pidx_in      = pidx_ff;
      pv_in        = pv_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      halted_in    = halted_ff;
      broke_in     = broke_ff;
      trunc_in     = trunc_ff;
      n_in         = n_ff;
      rd_ptr_in    = rd_ptr_ff;
      buf_we       = 1'b0;
      buf_wdata    = {1'b0, pend_y_ff, pend_x_ff};
      mac_ctl      = '0;
      mac_a        = scale_x_ff;
      mac_b        = $signed({3'b000, wx_ff[14:0]});
      rlast_in     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (f_cmd == CMD_DRAW)) begin
               code_in  = f_code;
               first_in = f_first;
               lastc_in = req_tlast;
               n_in     = '0;
               broke_in = 1'b0;
               if (f_first) begin
                  pen_x_in  = '0;
                  pidx_in   = '0;
                  pv_in     = 1'b0;
                  pend_x_in = '0;
                  pend_y_in = '0;
                  halted_in = 1'b0;
               end
               if (small_ff) begin
                  small_run_in = 1'b1;
                  st_in        = T_OFF;
                  trunc_in     = 1'b0;
                  state_in     = S_END;
               end else if (!halted_ff || f_first) begin
                  small_run_in = 1'b0;
                  state_in     = S_LOOK;
               end
            end
         end
         // table read issued at code_ff; character origin becomes pending
         S_LOOK: begin
            pv_in     = 1'b1;
            pend_x_in = pen_x_ff;
            pend_y_in = '0;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cnt_in   = cnt_rd;
            pair_in  = '0;
            vaddr_in = VADDR_W'(off_rd);
            state_in = (cnt_rd == '0) ? S_END : S_RDX;
         end
         // x word read issued
         S_RDX: begin
            vaddr_in = vaddr_ff + VADDR_W'(1);
            state_in = S_RDY;
         end
         // y word read issued, x word arrives
         S_RDY: begin
            wx_in    = vec_rd;
            vaddr_in = vaddr_ff + VADDR_W'(1);
            state_in = S_M0;
         end
         // y arrives; product ix * scale_x
         S_M0: begin
            iy_in         = $signed({2'b00, vec_rd}) - $signed(Y_BIAS);
            mac_ctl.issue = 1'b1;
            state_in      = S_M1;
         end
         S_M1: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.load  = 1'b1;
            mac_a         = shear_ff;
            mac_b         = iy_ff;
            state_in      = S_M2;
         end
         S_M2: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.accum = 1'b1;
            mac_a         = scale_y_ff;
            mac_b         = iy_ff;
            state_in      = S_M3;
         end
         S_M3: begin
            px_in        = sat32({{32{pen_x_ff[31]}}, pen_x_ff} + rnd8(acc));
            mac_ctl.load = 1'b1;
            state_in     = S_M4;
         end
         S_M4: begin
            py_in    = sat32(rnd8(acc));
            state_in = S_EMIT;
         end
         // hidden moves merge into the pending point
         S_EMIT: begin
            if (wx_ff[15]) begin
               pv_in     = 1'b1;
               pend_x_in = px_ff;
               pend_y_in = py_ff;
               state_in  = S_CHK;
            end else begin
               if (pv_ff) begin
                  buf_we  = 1'b1;
                  n_in    = n_ff + 1'b1;
                  pidx_in = pidx_ff + 1'b1;
                  pv_in   = 1'b0;
               end
               state_in = S_VIS;
            end
         end
         S_VIS: begin
            buf_we    = 1'b1;
            buf_wdata = {1'b1, py_ff, px_ff};
            n_in      = n_ff + 1'b1;
            pidx_in   = pidx_ff + 1'b1;
            state_in  = S_CHK;
         end
         S_CHK: begin
            if (32'(lim_sum) >= POINT_LIMIT - 1) begin
               broke_in = 1'b1;
               state_in = S_END;
            end else if (pair_ff == cnt_ff - CNT_W'(1)) begin
               state_in = S_END;
            end else begin
               pair_in  = pair_ff + CNT_W'(1);
               state_in = S_RDX;
            end
         end
         // end of character, or the small-text steps
         S_END: begin
            if (small_run_ff) begin
               unique case (st_ff)
                  T_OFF: begin
                     if (first_ff) begin
                        buf_we    = 1'b1;
                        buf_wdata = '0;
                        n_in      = n_ff + 1'b1;
                     end
                     st_in = T_ADV;
                  end
                  T_ADV: begin
                     pen_x_in = sat32({{32{pen_x_ff[31]}}, pen_x_ff}
                                    + {{32{advance_ff[31]}}, advance_ff});
                     st_in    = T_LAST;
                  end
                  T_LAST: begin
                     if (lastc_ff) begin
                        buf_we    = 1'b1;
                        buf_wdata = {1'b1, 32'd0, pen_x_ff};
                        n_in      = n_ff + 1'b1;
                     end
                     rd_ptr_in = '0;
                     state_in  = (n_in == '0) ? S_IDLE : S_DRD;
                  end
                  default: st_in = T_OFF;
               endcase
            end else begin
               pv_in     = 1'b0;
               pen_x_in  = sat32({{32{pen_x_ff[31]}}, pen_x_ff}
                               + {{32{advance_ff[31]}}, advance_ff});
               trunc_in  = broke_ff || at_end_lim;
               halted_in = halted_ff || broke_ff || at_end_lim;
               rd_ptr_in = '0;
               state_in  = (n_ff == '0) ? S_IDLE : S_DRD;
            end
         end
         // buffer read once the output register frees up
         S_DRD: begin
            if (out_free) begin
               state_in = S_DLD;
            end
         end
         S_DLD: begin
            rlast_in  = (rd_ptr_ff + 1'b1 == n_ff);
            rd_ptr_in = rd_ptr_ff + 1'b1;
            state_in  = rlast_in ? S_IDLE : S_DRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rv_in    = rv_ff;
      rdata_in = rdata_ff;
      ruser_in = ruser_ff;
      if (state_ff == S_DLD) begin
         rv_in    = 1'b1;
         rdata_in = buf_rd[63:0];
         ruser_in = {trunc_ff, buf_rd[64]};
      end else if (rsp_tready) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         st_ff        <= T_OFF;
         small_run_ff <= 1'b0;
         pen_x_ff     <= '0;
         pidx_ff      <= '0;
         pv_ff        <= 1'b0;
         pend_x_ff    <= '0;
         pend_y_ff    <= '0;
         halted_ff    <= 1'b0;
         broke_ff     <= 1'b0;
         trunc_ff     <= 1'b0;
         n_ff         <= '0;
         rd_ptr_ff    <= '0;
         rv_ff        <= 1'b0;
         rlast_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         st_ff        <= st_in;
         small_run_ff <= small_run_in;
         pen_x_ff     <= pen_x_in;
         pidx_ff      <= pidx_in;
         pv_ff        <= pv_in;
         pend_x_ff    <= pend_x_in;
         pend_y_ff    <= pend_y_in;
         halted_ff    <= halted_in;
         broke_ff     <= broke_in;
         trunc_ff     <= trunc_in;
         n_ff         <= n_in;
         rd_ptr_ff    <= rd_ptr_in;
         rv_ff        <= rv_in;
         if (state_ff == S_DLD) begin
            rlast_ff <= rlast_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      first_ff <= first_in;
      lastc_ff <= lastc_in;
      cnt_ff   <= cnt_in;
      pair_ff  <= pair_in;
      vaddr_ff <= vaddr_in;
      wx_ff    <= wx_in;
      iy_ff    <= iy_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      rdata_ff <= rdata_in;
      ruser_ff <= ruser_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;
   assign rsp_tlast  = rlast_ff;

   // checks
   `SFV_NEVER(a_buf_overflow, clock, reset, n_ff > (RES_AW+1)'(RES_DEPTH))
   `SFV_NEVER(a_pidx_range, clock, reset, 32'(pidx_ff) >= POINT_LIMIT)
   `SFV_ASSERT(a_break_halts, clock, reset, (state_ff == S_END && !small_run_ff && broke_ff) |=> halted_ff)
   `SFV_ASSERT(a_drain_bound, clock, reset, (state_ff == S_DLD) |-> (rd_ptr_ff < n_ff))

endmodule
`default_nettype wire
